// File: design/rbm_pkg.sv
// shared types and constants for the robustness budget monitor
`timescale 1ns / 1ps
package rbm_pkg;
   localparam int DEPTH = 128;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam logic [23:0] MASK24 = 24'hFFFFFF;
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   localparam logic [2:0] REG_INITIAL = 3'd0;
   localparam logic [2:0] REG_BASELINE = 3'd1;
   localparam logic [2:0] REG_DECAY = 3'd2;
   localparam logic [2:0] REG_LENGTH = 3'd3;
   localparam logic [2:0] REG_THRESHOLD = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_UPDATE, ST_DECAY, ST_SUM, ST_DIV, ST_DEV, ST_DEVDIV, ST_SQRT, ST_OUT
   } state_type;

   typedef struct packed {
      logic start_item;   // latch input and do budget update
      logic do_decay;
      logic start_sum;
      logic start_div;    // mean division
      logic start_dev;
      logic start_devdiv;
      logic start_sqrt;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic div_done;
      logic sqrt_done;
   } status_type;
endpackage

// File: design/rbm_ctrl.sv
// sequencer for the robustness budget monitor
`timescale 1ns / 1ps
module rbm_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_fire,
   input  logic out_free,
   input  rbm_pkg::status_type status,
   output rbm_pkg::cmd_type cmd,
   output logic busy
);
   rbm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rbm_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         rbm_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (req_fire) begin
               cmd.start_item = 1'b1;
               state_in = rbm_pkg::ST_UPDATE;
            end
         end
         rbm_pkg::ST_UPDATE: begin
            cmd.do_decay = 1'b1;
            state_in = rbm_pkg::ST_DECAY;
         end
         rbm_pkg::ST_DECAY: begin
            cmd.start_sum = 1'b1;
            state_in = rbm_pkg::ST_SUM;
         end
         rbm_pkg::ST_SUM: if (status.walk_done) begin
            cmd.start_div = 1'b1;
            state_in = rbm_pkg::ST_DIV;
         end
         rbm_pkg::ST_DIV: if (status.div_done) begin
            cmd.start_dev = 1'b1;
            state_in = rbm_pkg::ST_DEV;
         end
         rbm_pkg::ST_DEV: if (status.walk_done) begin
            cmd.start_devdiv = 1'b1;
            state_in = rbm_pkg::ST_DEVDIV;
         end
         rbm_pkg::ST_DEVDIV: if (status.div_done) begin
            cmd.start_sqrt = 1'b1;
            state_in = rbm_pkg::ST_SQRT;
         end
         rbm_pkg::ST_SQRT: if (status.sqrt_done) state_in = rbm_pkg::ST_OUT;
         rbm_pkg::ST_OUT: if (out_free) begin
            cmd.load_out = 1'b1;
            state_in = rbm_pkg::ST_IDLE;
         end
         default: state_in = rbm_pkg::ST_IDLE;
      endcase
   end
endmodule

// File: design/rbm_datapath.sv
// budget arithmetic, history ring, window walker, divider and square root
`timescale 1ns / 1ps
module rbm_datapath (
   input  logic clock,
   input  logic reset,
   input  rbm_pkg::cmd_type cmd,
   output rbm_pkg::status_type status,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [23:0] csr_wdata,
   input  logic in_opcode,
   input  logic [23:0] in_robustness,
   output logic [23:0] budget,
   output logic [31:0] violations,
   output logic healthy,
   output logic [7:0] window_count,
   output logic [23:0] window_mean,
   output logic [23:0] window_min,
   output logic [23:0] window_max,
   output logic [23:0] window_std
);
   localparam int PW = rbm_pkg::PTR_W;
   localparam int CW = rbm_pkg::CNT_W;

   logic [23:0] init_ff, base_ff, thr_ff;
   logic [16:0] decay_ff;
   logic [7:0] len_ff;
   logic [23:0] budget_ff;
   logic [31:0] viol_ff;
   logic [PW-1:0] wp_ff;
   logic [CW-1:0] fill_ff;
   logic [23:0] ring [rbm_pkg::DEPTH];

   // effective window length
   logic [CW-1:0] eff_len, eff_of_wdata;
   function automatic logic [CW-1:0] clamp_len(input logic [7:0] l);
      logic [CW-1:0] r;
      if (l == 8'd0) r = CW'(1);
      else if (32'(l) > rbm_pkg::DEPTH) r = CW'(rbm_pkg::DEPTH);
      else r = CW'(l);
      return r;
   endfunction
   assign eff_len = clamp_len(len_ff);
   assign eff_of_wdata = clamp_len(csr_wdata[7:0]);

   // budget update
   logic signed [25:0] bsum;
   logic [23:0] bclamp;
   logic [16:0] dsat;
   logic [40:0] dprod;
   logic [23:0] preb_ff;
   assign bsum = $signed({2'b00, budget_ff}) + $signed({{2{in_robustness[23]}}, in_robustness})
               - $signed({{2{base_ff[23]}}, base_ff});
   assign bclamp = bsum[25] ? 24'd0 : (bsum[24] ? rbm_pkg::MASK24 : bsum[23:0]);
   assign dsat = (decay_ff > rbm_pkg::ONE_Q16) ? rbm_pkg::ONE_Q16 : decay_ff;
   assign dprod = preb_ff * (rbm_pkg::ONE_Q16 - dsat);

   // walker and arithmetic units
   logic walking_ff, dev_phase_ff;
   logic [CW-1:0] widx_ff;
   logic [PW-1:0] start_ptr;
   logic [23:0] rdata_ff;
   logic rvalid_ff;
   logic [31:0] sum_ff;
   logic [23:0] mn_ff, mx_ff, mean_ff, std_val;
   logic [55:0] dev_ff;
   logic [23:0] diff;
   logic [47:0] sq_ff;
   logic sq_valid_ff;
   logic walk_last_ff, rlast_ff, sqlast_ff, sumlast_ff, devlast_ff;

   assign start_ptr = wp_ff - PW'(fill_ff);
   assign diff = (rdata_ff >= mean_ff) ? rdata_ff - mean_ff : mean_ff - rdata_ff;

   // restoring divider: 56-bit dividend by count
   logic div_run_ff;
   logic [5:0] div_i_ff;
   logic [55:0] quo_ff;
   logic [CW:0] rem_ff;
   logic [CW:0] rem_sh;
   assign rem_sh = {rem_ff[CW-1:0], quo_ff[55]};

   // square root, two bits per cycle
   logic sq_run_ff;
   logic [47:0] sx_ff, sres_ff, sbit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 24'd65536; base_ff <= 24'd6554; decay_ff <= '0;
         len_ff <= 8'd100; thr_ff <= '0;
         budget_ff <= 24'd65536; viol_ff <= '0; wp_ff <= '0; fill_ff <= '0;
         walking_ff <= 1'b0; rvalid_ff <= 1'b0; sq_valid_ff <= 1'b0;
         div_run_ff <= 1'b0; sq_run_ff <= 1'b0;
         walk_last_ff <= 1'b0; rlast_ff <= 1'b0; sqlast_ff <= 1'b0;
         sumlast_ff <= 1'b0; devlast_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rbm_pkg::REG_INITIAL: init_ff <= csr_wdata;
               rbm_pkg::REG_BASELINE: base_ff <= csr_wdata;
               rbm_pkg::REG_DECAY: decay_ff <= csr_wdata[16:0];
               rbm_pkg::REG_LENGTH: begin
                  len_ff <= csr_wdata[7:0];
                  if (fill_ff > eff_of_wdata) fill_ff <= eff_of_wdata;
               end
               rbm_pkg::REG_THRESHOLD: thr_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.start_item) begin
            if (in_opcode) begin
               budget_ff <= init_ff; viol_ff <= '0; wp_ff <= '0; fill_ff <= '0;
               preb_ff <= init_ff;
            end else begin
               preb_ff <= bclamp;
               budget_ff <= bclamp;
               if (in_robustness[23] && viol_ff != 32'hFFFFFFFF) viol_ff <= viol_ff + 32'd1;
               if (fill_ff < eff_len) fill_ff <= fill_ff + CW'(1);
            end
         end
         if (cmd.do_decay && !in_opcode) begin
            if (dsat != 17'd0) begin
               budget_ff <= dprod[39:16];
               ring[wp_ff] <= dprod[39:16];
            end else ring[wp_ff] <= preb_ff;
            wp_ff <= wp_ff + PW'(1);
         end
         // window walk: read, then accumulate
         if (cmd.start_sum || cmd.start_dev) begin
            walking_ff <= (fill_ff != '0);
            walk_last_ff <= (fill_ff == '0);
            dev_phase_ff <= cmd.start_dev;
            widx_ff <= '0;
            if (cmd.start_sum) begin
               sum_ff <= '0; mn_ff <= rbm_pkg::MASK24; mx_ff <= '0;
            end else dev_ff <= '0;
         end else begin
            walk_last_ff <= 1'b0;
            if (walking_ff) begin
               widx_ff <= widx_ff + CW'(1);
               if (widx_ff + CW'(1) == fill_ff) walking_ff <= 1'b0;
            end
         end
         rvalid_ff <= walking_ff;
         rlast_ff <= walking_ff && (widx_ff + CW'(1) == fill_ff);
         if (walking_ff) rdata_ff <= ring[start_ptr + widx_ff[PW-1:0]];
         sq_valid_ff <= rvalid_ff && dev_phase_ff;
         sqlast_ff <= rlast_ff && dev_phase_ff;
         sq_ff <= diff * diff;
         // done flags are registered, so they rise in the cycle after the last accumulation
         sumlast_ff <= rlast_ff && !dev_phase_ff;
         devlast_ff <= sqlast_ff;
         if (rvalid_ff && !dev_phase_ff) begin
            sum_ff <= sum_ff + 32'(rdata_ff);
            if (rdata_ff < mn_ff) mn_ff <= rdata_ff;
            if (rdata_ff > mx_ff) mx_ff <= rdata_ff;
         end
         if (sq_valid_ff) dev_ff <= dev_ff + 56'(sq_ff);
         // divider
         if (cmd.start_div || cmd.start_devdiv) begin
            div_run_ff <= (fill_ff != '0);
            div_i_ff <= '0;
            quo_ff <= (fill_ff == '0) ? '0 : (cmd.start_div ? 56'(sum_ff) : dev_ff);
            rem_ff <= '0;
         end else if (div_run_ff) begin
            if (rem_sh >= {1'b0, fill_ff}) begin
               rem_ff <= rem_sh - {1'b0, fill_ff};
               quo_ff <= {quo_ff[54:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[54:0], 1'b0};
            end
            div_i_ff <= div_i_ff + 6'd1;
            if (div_i_ff == 6'd55) div_run_ff <= 1'b0;
         end
         if (cmd.start_dev) mean_ff <= quo_ff[23:0];
         // sqrt
         if (cmd.start_sqrt) begin
            sx_ff <= quo_ff[47:0]; sres_ff <= '0; sbit_ff <= 48'h4 << 44;
            sq_run_ff <= 1'b1;
         end else if (sq_run_ff) begin
            if (sx_ff >= sres_ff + sbit_ff) begin
               sx_ff <= sx_ff - (sres_ff + sbit_ff);
               sres_ff <= (sres_ff >> 1) + sbit_ff;
            end else sres_ff <= sres_ff >> 1;
            sbit_ff <= sbit_ff >> 2;
            if (sbit_ff == 48'd1) sq_run_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.walk_done = walk_last_ff || sumlast_ff || devlast_ff;
      status.div_done = !div_run_ff && !cmd.start_div && !cmd.start_devdiv;
      status.sqrt_done = !sq_run_ff && !cmd.start_sqrt;
   end

   assign std_val = sres_ff[23:0];
   assign budget = budget_ff;
   assign violations = viol_ff;
   assign healthy = budget_ff >= thr_ff;
   assign window_count = 8'(fill_ff);
   assign window_mean = (fill_ff == '0) ? 24'd0 : mean_ff;
   assign window_min = (fill_ff == '0) ? 24'd0 : mn_ff;
   assign window_max = (fill_ff == '0) ? 24'd0 : mx_ff;
   assign window_std = (fill_ff == '0) ? 24'd0 : std_val;
endmodule

// File: design/robustness_budget_monitor.sv
// top level of the robustness budget monitor
//  channel | dir | fields
//  req_    | in  | tuser=opcode, tdata=robustness[23:0]
//  rsp_    | out | tdata: budget, violations, healthy, count, mean, min, max, std
//  csr_    | in  | we, index[2:0], wdata[23:0]
// one transaction at a time: two window walks, two 56-step divides and a 24-step
// square root from acceptance to result, the walks and divides skipped with an empty
// window; result held in an output register, next request taken the cycle after the
// result register is loaded, and loading waits while the previous result is stalled.
// reset synchronous, high. the history ring is not cleared.
`timescale 1ns / 1ps
module robustness_budget_monitor (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,   // robustness
   input  logic req_tuser,          // opcode
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // budget[23:0] violations[55:24] healthy[56] count[64:57] mean[88:65]
   // min[112:89] max[136:113] std[160:137]
   output logic [167:0] rsp_tdata,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [23:0] csr_wdata
);
   rbm_pkg::cmd_type cmd;
   rbm_pkg::status_type status;
   logic busy, req_fire, out_free;
   logic op_ff;
   logic [23:0] rob_ff;
   logic [23:0] b, mean, mn, mx, sd;
   logic [31:0] v;
   logic h;
   logic [7:0] cnt;
   logic [167:0] rsp_ff;
   logic rsp_valid_ff;

   assign req_tready = !busy;
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff <= req_tuser;
         rob_ff <= req_tdata;
      end
   end

   rbm_ctrl u_ctrl (.clock, .reset, .req_fire, .out_free, .status, .cmd, .busy);

   rbm_datapath u_dp (
      .clock, .reset, .cmd, .status, .csr_we, .csr_index, .csr_wdata,
      .in_opcode(cmd.start_item ? req_tuser : op_ff),
      .in_robustness(cmd.start_item ? req_tdata : rob_ff),
      .budget(b), .violations(v), .healthy(h), .window_count(cnt),
      .window_mean(mean), .window_min(mn), .window_max(mx), .window_std(sd)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.load_out) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
      if (cmd.load_out) rsp_ff <= {7'd0, sd, mx, mn, mean, cnt, h, v, b};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_fire) else $error("request taken while busy");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready)) else $error("result overwritten");
   a_fire_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy) else $error("no work after request");
endmodule
